FILE: sv/ves_pkg.sv
package ves_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [3:0] REG_CR     = 4'd0;
  localparam logic [3:0] REG_LVOL   = 4'd2;
  localparam logic [3:0] REG_LVRAMP = 4'd3;
  localparam logic [3:0] REG_RVOL   = 4'd4;
  localparam logic [3:0] REG_RVRAMP = 4'd5;
  localparam logic [3:0] REG_ECOUNT = 4'd6;
  localparam logic [3:0] REG_K2     = 4'd7;
  localparam logic [3:0] REG_K2RAMP = 4'd8;
  localparam logic [3:0] REG_K1     = 4'd9;
  localparam logic [3:0] REG_K1RAMP = 4'd10;

  localparam logic [2:0]  CHAN_MAX   = 3'd5;
  localparam logic [4:0]  SHIFT_BASE = 5'd20;
  localparam logic [31:0] READ_IDLE  = 32'hffff_ffff;
  localparam logic [15:0] VOL_MAX    = 16'hffff;

  typedef struct packed {
    logic [15:0] lvol;
    logic [15:0] rvol;
    logic [7:0]  lramp;
    logic [7:0]  rramp;
    logic [8:0]  ecount;
    logic [15:0] k1;
    logic [15:0] k2;
    logic [8:0]  k1ramp;
    logic [8:0]  k2ramp;
    logic [2:0]  phase;
    logic [2:0]  chan;
  } voice_t;

  typedef struct packed {
    logic capture;
    logic mult;
    logic commit;
  } dp_cmd_t;

  function automatic logic [15:0] ramp_add(input logic [15:0] value, input logic [7:0] ramp);
    logic [17:0] sum;
    sum = {2'b00, value} + {{10{ramp[7]}}, ramp};
    if (sum[17]) begin
      ramp_add = '0;
    end else if (sum[16]) begin
      ramp_add = VOL_MAX;
    end else begin
      ramp_add = sum[15:0];
    end
  endfunction

endpackage

FILE: sv/ves_in_if.sv
interface ves_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [4:0]         voice_index;
  logic [3:0]         reg_addr;
  logic [31:0]        write_data;
  logic signed [15:0] filter_out;
  logic               alu_busy;
  logic               mute;

  modport source (
    output valid, command, voice_index, reg_addr, write_data, filter_out, alu_busy, mute,
    input  ready
  );
  modport sink (
    input  valid, command, voice_index, reg_addr, write_data, filter_out, alu_busy, mute,
    output ready
  );
endinterface

FILE: sv/ves_out_if.sv
interface ves_out_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] left_out;
  logic signed [19:0] right_out;
  logic [2:0]         out_channel;
  logic [15:0]        coef_one;
  logic [15:0]        coef_two;
  logic [31:0]        read_data;

  modport source (
    output valid, left_out, right_out, out_channel, coef_one, coef_two, read_data,
    input  ready
  );
  modport sink (
    input  valid, left_out, right_out, out_channel, coef_one, coef_two, read_data,
    output ready
  );
endinterface

FILE: sv/voice_envelope_volume_stage_top.sv
// An input transfer is captured, then the voice multiply stage runs, then the
// commit stage writes the voice entry back and registers the result; commit
// waits while the output holds an untaken result. A new item is taken during
// commit, not during multiply. Reset: asynchronous, active low; clears all
// voice state at once, so the block takes items as soon as reset is released.
module voice_envelope_volume_stage_top #(
  parameter int NUM_VOICES = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ves_in_if.sink   in_i,
  ves_out_if.source out_o
);
  import ves_pkg::*;

  dp_cmd_t cmd;

  ves_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  ves_dp #(
    .NUM_VOICES (NUM_VOICES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .command_i     (in_i.command),
    .voice_index_i (in_i.voice_index),
    .reg_addr_i    (in_i.reg_addr),
    .write_data_i  (in_i.write_data),
    .filter_out_i  (in_i.filter_out),
    .alu_busy_i    (in_i.alu_busy),
    .mute_i        (in_i.mute),
    .left_out_o    (out_o.left_out),
    .right_out_o   (out_o.right_out),
    .out_channel_o (out_o.out_channel),
    .coef_one_o    (out_o.coef_one),
    .coef_two_o    (out_o.coef_two),
    .read_data_o   (out_o.read_data)
  );
endmodule

FILE: sv/ves_ctrl.sv
module ves_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ves_pkg::dp_cmd_t cmd_o
);
  import ves_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_DONE) && out_free);
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.capture = accept;
  assign cmd_o.mult    = (state_q == S_CALC);
  assign cmd_o.commit  = (state_q == S_DONE) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_CALC;
      end
      S_CALC: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = accept ? S_CALC : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

FILE: sv/ves_dp.sv
module ves_dp #(
  parameter int NUM_VOICES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ves_pkg::dp_cmd_t   cmd_i,
  input  logic [1:0]         command_i,
  input  logic [4:0]         voice_index_i,
  input  logic [3:0]         reg_addr_i,
  input  logic [31:0]        write_data_i,
  input  logic signed [15:0] filter_out_i,
  input  logic               alu_busy_i,
  input  logic               mute_i,
  output logic signed [19:0] left_out_o,
  output logic signed [19:0] right_out_o,
  output logic [2:0]         out_channel_o,
  output logic [15:0]        coef_one_o,
  output logic [15:0]        coef_two_o,
  output logic [31:0]        read_data_o
);
  import ves_pkg::*;

  localparam int         IdxW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam logic [5:0] NumV = 6'(NUM_VOICES);

  voice_t voices_q [NUM_VOICES];

  logic [1:0]         cmd_q;
  logic [IdxW-1:0]    idx_q;
  logic               hit_q;
  logic [3:0]         addr_q;
  logic [31:0]        wdata_q;
  logic signed [15:0] sample_q;
  logic               play_q;

  logic signed [25:0] lprod_q, rprod_q;
  logic [4:0]         lshift_q, rshift_q;

  voice_t             ent, nxt;
  logic               pz;
  logic [2:0]         wr_chan;
  logic [31:0]        rd;
  logic signed [25:0] lshifted, rshifted;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q    <= command_i;
      idx_q    <= voice_index_i[IdxW-1:0];
      hit_q    <= ({1'b0, voice_index_i} < NumV) && (command_i != CMD_NOP);
      addr_q   <= reg_addr_i;
      wdata_q  <= write_data_i;
      sample_q <= filter_out_i;
      play_q   <= alu_busy_i && !mute_i;
    end
  end

  assign ent = voices_q[idx_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mult) begin
      lprod_q  <= sample_q * $signed({2'b01, ent.lvol[11:4]});
      rprod_q  <= sample_q * $signed({2'b01, ent.rvol[11:4]});
      lshift_q <= SHIFT_BASE - {1'b0, ent.lvol[15:12]};
      rshift_q <= SHIFT_BASE - {1'b0, ent.rvol[15:12]};
    end
  end

  assign pz      = (ent.phase == 3'd0);
  assign wr_chan = (wdata_q[12:10] > CHAN_MAX) ? CHAN_MAX : wdata_q[12:10];

  always_comb begin
    nxt = ent;
    unique case (cmd_q)
      CMD_TICK: begin
        if (ent.ecount != 9'd0) begin
          if (ent.lramp != 8'd0) nxt.lvol = ramp_add(ent.lvol, ent.lramp);
          if (ent.rramp != 8'd0) nxt.rvol = ramp_add(ent.rvol, ent.rramp);
          if ((ent.k1ramp[8:1] != 8'd0) && (!ent.k1ramp[0] || pz)) begin
            nxt.k1 = ramp_add(ent.k1, ent.k1ramp[8:1]);
          end
          if ((ent.k2ramp[8:1] != 8'd0) && (!ent.k2ramp[0] || pz)) begin
            nxt.k2 = ramp_add(ent.k2, ent.k2ramp[8:1]);
          end
          nxt.ecount = ent.ecount - 9'd1;
        end
        nxt.phase = ent.phase + 3'd1;
      end
      CMD_WRITE: begin
        unique case (addr_q)
          REG_CR:     nxt.chan   = wr_chan;
          REG_LVOL:   nxt.lvol   = wdata_q[15:0];
          REG_LVRAMP: nxt.lramp  = wdata_q[15:8];
          REG_RVOL:   nxt.rvol   = wdata_q[15:0];
          REG_RVRAMP: nxt.rramp  = wdata_q[15:8];
          REG_ECOUNT: nxt.ecount = wdata_q[8:0];
          REG_K2:     nxt.k2     = wdata_q[15:0];
          REG_K2RAMP: nxt.k2ramp = {wdata_q[15:8], wdata_q[0]};
          REG_K1:     nxt.k1     = wdata_q[15:0];
          REG_K1RAMP: nxt.k1ramp = {wdata_q[15:8], wdata_q[0]};
          default:    nxt = ent;
        endcase
      end
      default: begin
        nxt = ent;
      end
    endcase
  end

  always_comb begin
    rd = READ_IDLE;
    unique case (addr_q)
      REG_CR:     rd[15:0] = {3'b000, ent.chan, 10'd0};
      REG_LVOL:   rd[15:0] = ent.lvol;
      REG_LVRAMP: rd[15:8] = ent.lramp;
      REG_RVOL:   rd[15:0] = ent.rvol;
      REG_RVRAMP: rd[15:8] = ent.rramp;
      REG_ECOUNT: rd[8:0]  = ent.ecount;
      REG_K2:     rd[15:0] = ent.k2;
      REG_K2RAMP: begin
        rd[15:8] = ent.k2ramp[8:1];
        rd[0]    = ent.k2ramp[0];
      end
      REG_K1:     rd[15:0] = ent.k1;
      REG_K1RAMP: begin
        rd[15:8] = ent.k1ramp[8:1];
        rd[0]    = ent.k1ramp[0];
      end
      default:    rd = READ_IDLE;
    endcase
  end

  assign lshifted = lprod_q >>> lshift_q;
  assign rshifted = rprod_q >>> rshift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        voices_q[i] <= '0;
      end
    end else if (cmd_i.commit && hit_q) begin
      voices_q[idx_q] <= nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (hit_q && (cmd_q == CMD_TICK) && play_q) begin
        left_out_o  <= lshifted[19:0];
        right_out_o <= rshifted[19:0];
      end else begin
        left_out_o  <= '0;
        right_out_o <= '0;
      end
      out_channel_o <= hit_q ? nxt.chan : 3'd0;
      coef_one_o    <= hit_q ? nxt.k1 : 16'd0;
      coef_two_o    <= hit_q ? nxt.k2 : 16'd0;
      read_data_o   <= (hit_q && (cmd_q == CMD_READ)) ? rd : READ_IDLE;
    end
  end
endmodule
